@@ src/rrs_pkg.sv @@
// shared constants, codes and types of the round-robin time-slice scheduler
`default_nettype none
package rrs_pkg;
	localparam int SLOTS = 4;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int LIM_W = (CNT_W > 3) ? CNT_W : 3;

	localparam logic [15:0] TIME_SLICE_RST = 16'd10;
	localparam logic [2:0] MAX_TASKS_RST = 3'd3;

	localparam logic REG_TIME_SLICE = 1'b0;
	localparam logic REG_MAX_TASKS = 1'b1;

	localparam logic REQ_SUBMIT = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [1:0] STAT_ACCEPTED = 2'd0;
	localparam logic [1:0] STAT_REJECTED = 2'd1;
	localparam logic [1:0] STAT_SERVED = 2'd2;
	localparam logic [1:0] STAT_IDLE = 2'd3;

	typedef struct packed {
		logic [15:0] time_slice;
		logic [2:0] max_tasks;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic [SLOT_W-1:0] idx;
		logic valid;
		logic [7:0] id;
		logic [15:0] rem;
	} slot_wr_t;

	typedef struct packed {
		logic valid;
		logic [7:0] id;
		logic [15:0] rem;
	} slot_rd_t;
endpackage
`default_nettype wire

@@ src/rrs_regs.sv @@
// configuration registers behind the apb port
`default_nettype none
module rrs_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output rrs_pkg::cfg_t cfg
);
	import rrs_pkg::*;

	logic [15:0] time_slice_q;
	logic [2:0] max_tasks_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= TIME_SLICE_RST;
			max_tasks_q <= MAX_TASKS_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_TIME_SLICE: time_slice_q <= pwdata[15:0];
				REG_MAX_TASKS: max_tasks_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TIME_SLICE: prdata = {16'd0, time_slice_q};
			REG_MAX_TASKS: prdata = {29'd0, max_tasks_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.time_slice = time_slice_q;
	assign cfg.max_tasks = max_tasks_q;
endmodule
`default_nettype wire

@@ src/rrs_slot_file.sv @@
// task slots: valid bits, ids and remaining times
`default_nettype none
module rrs_slot_file (
	input wire logic clk,
	input wire logic arst_n,
	input wire rrs_pkg::slot_wr_t wr,
	input wire logic [rrs_pkg::SLOT_W-1:0] rd_idx,
	output rrs_pkg::slot_rd_t rd
);
	import rrs_pkg::*;

	logic [SLOTS-1:0] valid_q;
	logic [7:0] id_q [SLOTS];
	logic [15:0] rem_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= wr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			id_q[wr.idx] <= wr.id;
			rem_q[wr.idx] <= wr.rem;
		end
	end

	assign rd.valid = valid_q[rd_idx];
	assign rd.id = id_q[rd_idx];
	assign rd.rem = rem_q[rd_idx];
endmodule
`default_nettype wire

@@ src/rrs_seq.sv @@
// slot scan sequencer with the shared saturating subtractor
`default_nettype none
module rrs_seq (
	input wire logic clk,
	input wire logic arst_n,
	input wire rrs_pkg::cfg_t cfg,
	input wire logic start,
	input wire logic req_type,
	input wire logic [7:0] task_id,
	input wire logic [15:0] duration,
	output logic busy,
	output logic done,
	output logic [1:0] status,
	output logic [1:0] slot,
	output logic [7:0] served_id,
	output logic [15:0] remaining,
	output logic completed,
	output logic [2:0] occupancy,
	output rrs_pkg::slot_wr_t wr,
	output logic [rrs_pkg::SLOT_W-1:0] rd_idx,
	input wire rrs_pkg::slot_rd_t rd
);
	import rrs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_SERVE = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [SLOT_W-1:0] next_q;
	logic done_q;
	logic req_q;
	logic [7:0] id_q;
	logic [15:0] dur_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0] step_q;
	logic [1:0] status_q;
	logic [1:0] slot_q;
	logic [7:0] served_id_q;
	logic [15:0] remaining_q;
	logic completed_q;
	logic [2:0] occupancy_q;

	logic accept;
	logic [LIM_W-1:0] mt_ext;
	logic [LIM_W-1:0] limit;
	logic [SLOT_W-1:0] idx_inc;
	logic sub_reject;
	logic sub_take;
	logic tick_idle;
	logic tick_found;
	logic [16:0] diff;
	logic [15:0] rem_new;
	logic finished;
	logic [CNT_W-1:0] count_dec;

	assign accept = start & ~busy;
	assign mt_ext = LIM_W'(cfg.max_tasks);
	assign limit = (mt_ext < LIM_W'(SLOTS)) ? mt_ext : LIM_W'(SLOTS);
	assign idx_inc = (idx_q == SLOT_W'(SLOTS - 1)) ? '0 : SLOT_W'(idx_q + 1'b1);

	assign sub_reject = (state_q == S_SCAN) && (req_q == REQ_SUBMIT) &&
		((LIM_W'(count_q) >= limit) || (LIM_W'(step_q) >= limit));
	assign sub_take = (state_q == S_SCAN) && (req_q == REQ_SUBMIT) && !sub_reject && !rd.valid;
	assign tick_idle = (state_q == S_SCAN) && (req_q == REQ_TICK) &&
		(step_q == CNT_W'(SLOTS));
	assign tick_found = (state_q == S_SCAN) && (req_q == REQ_TICK) && !tick_idle && rd.valid;

	// shared saturating subtractor
	assign diff = {1'b0, rd.rem} - {1'b0, cfg.time_slice};
	assign rem_new = diff[16] ? 16'd0 : diff[15:0];
	assign finished = (rem_new == 16'd0);
	assign count_dec = (count_q != '0) ? CNT_W'(count_q - 1'b1) : count_q;

	assign rd_idx = idx_q;

	always_comb begin
		wr.en = 1'b0;
		wr.idx = idx_q;
		wr.valid = 1'b1;
		wr.id = id_q;
		wr.rem = dur_q;
		if (sub_take) begin
			wr.en = 1'b1;
		end else if (state_q == S_SERVE) begin
			wr.en = 1'b1;
			wr.valid = ~finished;
			wr.id = rd.id;
			wr.rem = rem_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			next_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sub_reject || tick_idle) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end else if (sub_take) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						count_q <= CNT_W'(count_q + 1'b1);
					end else if (tick_found) begin
						state_q <= S_SERVE;
					end
				end
				S_SERVE: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
					next_q <= idx_inc;
					if (finished) begin
						count_q <= count_dec;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			id_q <= task_id;
			dur_q <= duration;
			step_q <= '0;
			idx_q <= (req_type == REQ_TICK) ? next_q : '0;
		end else if (state_q == S_SCAN && !tick_found) begin
			step_q <= CNT_W'(step_q + 1'b1);
			idx_q <= (req_q == REQ_TICK) ? idx_inc : SLOT_W'(idx_q + 1'b1);
		end

		if (sub_reject) begin
			status_q <= STAT_REJECTED;
			slot_q <= '0;
			served_id_q <= '0;
			remaining_q <= '0;
			completed_q <= 1'b0;
			occupancy_q <= 3'(count_q);
		end else if (tick_idle) begin
			status_q <= STAT_IDLE;
			slot_q <= '0;
			served_id_q <= '0;
			remaining_q <= '0;
			completed_q <= 1'b0;
			occupancy_q <= '0;
		end else if (sub_take) begin
			status_q <= STAT_ACCEPTED;
			slot_q <= 2'(idx_q);
			served_id_q <= id_q;
			remaining_q <= dur_q;
			completed_q <= 1'b0;
			occupancy_q <= 3'(CNT_W'(count_q + 1'b1));
		end else if (state_q == S_SERVE) begin
			status_q <= STAT_SERVED;
			slot_q <= 2'(idx_q);
			served_id_q <= rd.id;
			remaining_q <= rem_new;
			completed_q <= finished;
			occupancy_q <= 3'(finished ? count_dec : count_q);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign slot = slot_q;
	assign served_id = served_id_q;
	assign remaining = remaining_q;
	assign completed = completed_q;
	assign occupancy = occupancy_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while sequencer not idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		LIM_W'(count_q) <= LIM_W'(SLOTS))
		else $error("task count above slot count");

	a_completed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && completed_q) |-> (status_q == STAT_SERVED && remaining_q == 16'd0))
		else $error("completed task with time left");

	a_serve_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SERVE) |-> rd.valid)
		else $error("serving an empty slot");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");
endmodule
`default_nettype wire

@@ src/round_robin_time_slice_scheduler.sv @@
// top level of the round-robin time-slice scheduler
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result appears for one cycle with done high, and a new
// transaction may be started in that same cycle. The sequencer looks at one
// slot per cycle and a single subtractor charges the time slice. A submit
// examines slots from slot 0 upward, at most as many as the task limit, and
// is rejected when the task count has reached the limit or no free slot lies
// below it; a tick scans slots from the round-robin pointer, then charges the
// first valid slot found in a separate step, or reports idle once every slot
// has been scanned.
// Results cannot be held off and must be taken in the cycle done is high.
`default_nettype none
module round_robin_time_slice_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic req_type,
	input wire logic [7:0] task_id,
	input wire logic [15:0] duration,
	output logic done,
	output logic [1:0] status,
	output logic [1:0] slot,
	output logic [7:0] served_id,
	output logic [15:0] remaining,
	output logic completed,
	output logic [2:0] occupancy,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import rrs_pkg::*;

	cfg_t cfg;
	slot_wr_t wr;
	slot_rd_t rd;
	logic [SLOT_W-1:0] rd_idx;

	rrs_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	rrs_slot_file u_slots (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.rd_idx(rd_idx),
		.rd(rd)
	);

	rrs_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.start(start),
		.req_type(req_type),
		.task_id(task_id),
		.duration(duration),
		.busy(busy),
		.done(done),
		.status(status),
		.slot(slot),
		.served_id(served_id),
		.remaining(remaining),
		.completed(completed),
		.occupancy(occupancy),
		.wr(wr),
		.rd_idx(rd_idx),
		.rd(rd)
	);
endmodule
`default_nettype wire
